// ===== rtl/dfq_pkg.sv =====
// ----------------------------------------------------------------------------
// dfq_pkg: shared definitions for the deduplicating FIFO queue
// Sizes, action and status codes, and the control bundle broadcast to cells.
// ----------------------------------------------------------------------------
package dfq_pkg;

    localparam int DEPTH  = 64;
    localparam int ITEM_W = 32;
    localparam int POS_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CFG_W  = 7;
    localparam int ACT_W  = 2;
    localparam int ST_W   = 3;

    localparam logic [ACT_W-1:0] ACT_ENQ  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FIND = 2'd2;
    localparam logic [ACT_W-1:0] ACT_PEEK = 2'd3;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [ST_W-1:0] ST_RANGE    = 3'd5;

    // Byte address of the capacity register on the APB port.
    localparam logic [1:0] REG_CAPACITY = 2'd0;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic              shift;     // take the neighbor's entry (dequeue)
        logic              load;      // write key into the cell at load_pos
        logic [POS_W-1:0]  load_pos;
        logic [ITEM_W-1:0] key;       // value to compare or to load
        logic [POS_W-1:0]  peek_idx;  // position to read out
    } dfq_ctrl_t;

endpackage

// ===== rtl/dfq_cell.sv =====
// ----------------------------------------------------------------------------
// dfq_cell: one queue slot
// Holds one entry, shifts from its upper neighbor on dequeue, loads on
// enqueue, and registers its key match and peek contribution.
// ----------------------------------------------------------------------------
module dfq_cell (
    input  logic                          aclk,
    input  dfq_pkg::dfq_ctrl_t            ctrl,
    input  logic [dfq_pkg::POS_W-1:0]     cell_pos,
    input  logic [dfq_pkg::CNT_W-1:0]     count,
    input  logic [dfq_pkg::ITEM_W-1:0]    next_data,
    output logic [dfq_pkg::ITEM_W-1:0]    data,
    output logic                          hit,
    output logic [dfq_pkg::ITEM_W-1:0]    peek_data
);
    import dfq_pkg::*;

    logic [ITEM_W-1:0] data_reg;
    logic              hit_reg;
    logic [ITEM_W-1:0] peek_reg;
    logic              cell_valid;

    assign cell_valid = {1'b0, cell_pos} < count;

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            data_reg <= next_data;
        end else if (ctrl.load && (ctrl.load_pos == cell_pos)) begin
            data_reg <= ctrl.key;
        end
        hit_reg  <= cell_valid && (data_reg == ctrl.key);
        peek_reg <= (cell_valid && (cell_pos == ctrl.peek_idx)) ? data_reg : '0;
    end

    assign data      = data_reg;
    assign hit       = hit_reg;
    assign peek_data = peek_reg;

endmodule

// ===== rtl/dfq_chain.sv =====
// ----------------------------------------------------------------------------
// dfq_chain: row of queue cells
// Links the cells head to tail and merges their match and peek outputs.
// ----------------------------------------------------------------------------
module dfq_chain (
    input  logic                          aclk,
    input  dfq_pkg::dfq_ctrl_t            ctrl,
    input  logic [dfq_pkg::CNT_W-1:0]     count,
    output logic [dfq_pkg::ITEM_W-1:0]    head_data,
    output logic [dfq_pkg::DEPTH-1:0]     hit_vec,
    output logic [dfq_pkg::POS_W-1:0]     hit_pos,
    output logic [dfq_pkg::ITEM_W-1:0]    peek_data
);
    import dfq_pkg::*;

    logic [ITEM_W-1:0] cell_data [DEPTH];
    logic [ITEM_W-1:0] cell_next [DEPTH];
    logic [ITEM_W-1:0] cell_peek [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == DEPTH - 1) begin : g_tail
            assign cell_next[i] = '0;
        end else begin : g_link
            assign cell_next[i] = cell_data[i+1];
        end

        dfq_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .cell_pos  (POS_W'(i)),
            .count     (count),
            .next_data (cell_next[i]),
            .data      (cell_data[i]),
            .hit       (hit_vec[i]),
            .peek_data (cell_peek[i])
        );
    end

    assign head_data = cell_data[0];

    // Held values are unique, so at most one cell hits: OR the positions.
    always_comb begin
        hit_pos   = '0;
        peek_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_pos   = hit_pos | (hit_vec[i] ? POS_W'(i) : '0);
            peek_data = peek_data | cell_peek[i];
        end
    end

endmodule

// ===== rtl/dedup_fifo_queue_top.sv =====
// ----------------------------------------------------------------------------
// dedup_fifo_queue_top: FIFO queue that refuses duplicate values
// Usage:
//   s_ channel carries one request per transfer: enqueue, dequeue, find or
//   peek. m_ channel returns exactly one result per request, in order, with
//   a status code and the occupancy after the request.
//   The APB port holds the capacity register at byte address 0 (reset 64,
//   values above the queue depth act as the depth).
// Request flow:
//   A request passes through three steps: accept, cell compare, execute.
//   The next request is accepted only once the last one has executed; the
//   registered match stage in every cell and the merge of the cell outputs
//   set this. The result is registered onto m_ when the execute step fires.
// Reset:
//   Synchronous, active low; clears the count, the control state and the
//   output valid, and sets the capacity to 64. Slot contents are not cleared
//   since only slots below the count are ever read.
// Stall:
//   The next request is accepted while a result waits on m_; its execute
//   step holds until the output register is free.
// ----------------------------------------------------------------------------
module dedup_fifo_queue_top (
    input  logic        aclk,
    input  logic        aresetn,
    // action [1:0], item [33:2], index [39:34]
    input  logic [39:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // status [2:0], result_item [34:3], position [40:35], occupancy [47:41]
    output logic [47:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dfq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CFG_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ACT_W-1:0]  act_reg;
    logic [ITEM_W-1:0] key_reg;
    logic [POS_W-1:0]  idx_reg;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [ST_W-1:0]   status_reg, status_next;
    logic [ITEM_W-1:0] res_reg, res_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  occ_reg;

    dfq_ctrl_t         ctrl;
    logic [ITEM_W-1:0] head_data;
    logic [DEPTH-1:0]  hit_vec;
    logic [POS_W-1:0]  hit_pos;
    logic [ITEM_W-1:0] peek_data;

    logic              s_fire;
    logic              exec_fire;
    logic              dup;
    logic              full;
    logic [CNT_W-1:0]  cap_eff;
    logic              cfg_wr;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_CAPACITY);
    assign prdata = (paddr == REG_CAPACITY) ? {{(32-CFG_W){1'b0}}, capacity_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CFG_W'(DEPTH);
        end else if (cfg_wr) begin
            capacity_reg <= pwdata[CFG_W-1:0];
        end
    end

    // Saturate the capacity at the number of cells.
    assign cap_eff = (CNT_W'(capacity_reg) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                            : CNT_W'(capacity_reg);

    // ---------------- request capture ----------------
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            act_reg <= s_tdata[1:0];
            key_reg <= s_tdata[33:2];
            idx_reg <= s_tdata[39:34];
        end
    end

    // Execute only when the output register can take the result.
    assign exec_fire = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_fire) state_next = S_CMP;
            S_CMP:   state_next = S_EXEC;
            S_EXEC:  if (exec_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------- decision ----------------
    assign dup  = |hit_vec;
    assign full = (count_reg >= cap_eff);

    always_comb begin
        status_next = ST_OK;
        res_next    = '0;
        pos_next    = '0;
        count_next  = count_reg;
        ctrl.shift    = 1'b0;
        ctrl.load     = 1'b0;
        ctrl.load_pos = count_reg[POS_W-1:0];
        ctrl.key      = key_reg;
        ctrl.peek_idx = idx_reg;
        unique case (act_reg)
            ACT_ENQ: begin
                if (dup) begin
                    status_next = ST_DUP;
                end else if (full) begin
                    status_next = ST_FULL;
                end else begin
                    ctrl.load  = exec_fire;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_DEQ: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    res_next   = head_data;
                    ctrl.shift = exec_fire;
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_FIND: begin
                if (dup) begin
                    pos_next = hit_pos;
                end else begin
                    status_next = ST_NOTFOUND;
                end
            end
            ACT_PEEK: begin
                // Out-of-range cells contribute zero to peek_data.
                res_next = peek_data;
                if (CNT_W'(idx_reg) >= count_reg) begin
                    status_next = ST_RANGE;
                end
            end
            default: status_next = ST_OK;
        endcase
    end

    dfq_chain u_chain (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .count     (count_reg),
        .head_data (head_data),
        .hit_vec   (hit_vec),
        .hit_pos   (hit_pos),
        .peek_data (peek_data)
    );

    // ---------------- state and output registers ----------------
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (exec_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (exec_fire) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            status_reg <= status_next;
            res_reg    <= res_next;
            pos_reg    <= pos_next;
            occ_reg    <= count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {occ_reg, pos_reg, res_reg, status_reg};

    // ---------------- assertions ----------------
    // Held values are unique, so the cells never report two matches.
    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) |-> $onehot0(hit_vec))
        else $error("more than one cell matched the key");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("count exceeds the number of cells");

    // A pending result always reports the count that is held.
    a_occ_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (occ_reg == count_reg))
        else $error("reported occupancy differs from the held count");

endmodule
